FILE: rtl/wavetable_sound_generator_assert.svh
// assertion macros for the wavetable sound generator
// expects signals named clk and rst_n in the including scope
`ifndef WAVETABLE_SOUND_GENERATOR_ASSERT_SVH
`define WAVETABLE_SOUND_GENERATOR_ASSERT_SVH

// same-cycle implication, quiet during reset
`define WSG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define WSG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/wsg_pkg.sv
// shared constants, codes and types of the wavetable sound generator
// no dependencies
package wsg_pkg;

    // block sizes
    localparam int BLOCK_SAMPLES = 64;
    localparam int BOOM_DEPTH    = 4096;
    localparam int BLOCK_W       = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
    localparam int BOOM_AW       = $clog2(BOOM_DEPTH);

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int GAIN_W  = 7;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 7'd32;
    localparam logic REG_GAIN = 1'b0;

    // datapath widths
    localparam int SAMPLE_W = 8;
    localparam int PCM_W    = 16;
    localparam int ACC_W    = 27;
    localparam int PHASE_W  = 18;
    localparam int VOICES   = 3;

    // sound register map
    localparam int STEP_LOW_REG  = 'h10;
    localparam int STEP_REG_BASE = 'h11;
    localparam int VOL_REG_BASE  = 'h15;
    localparam int SEL_REG_BASE  = 'h05;
    localparam int VOICE_STRIDE  = 5;

    // host actions
    typedef enum logic [2:0] {
        ACT_REG_WR  = 3'd0,
        ACT_WAVE_WR = 3'd1,
        ACT_BOOM_WR = 3'd2,
        ACT_BOOM_GO = 3'd3,
        ACT_TICK    = 3'd4
    } action_t;

    // one operation of the shared multiply-accumulate unit
    typedef struct packed {
        logic                       en;
        logic                       clear;
        logic                       scale;
        logic signed [SAMPLE_W-1:0] sample;
        logic [7:0]                 coef;
    } mac_op_t;

endpackage

FILE: rtl/wsg_apb.sv
// configuration port: holds the output gain register
// depends on wsg_pkg
module wsg_apb
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wsg_pkg::PADDR_W-1:0]          paddr,
    input  logic [wsg_pkg::PDATA_W-1:0]          pwdata,
    output logic [wsg_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready,
    output logic [wsg_pkg::GAIN_W-1:0]           gain
);

    logic [wsg_pkg::GAIN_W-1:0] gain_reg;
    logic [wsg_pkg::GAIN_W-1:0] gain_next;
    logic                       reg_sel;

    // word decode, one register
    assign reg_sel = (paddr[wsg_pkg::PADDR_W-1] == wsg_pkg::REG_GAIN);
    assign pready  = 1'b1;

    always_comb
    begin
        gain_next = gain_reg;
        if (psel && penable && pwrite && reg_sel)
        begin
            gain_next = pwdata[wsg_pkg::GAIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= wsg_pkg::GAIN_RESET;
        end
        else
        begin
            gain_reg <= gain_next;
        end
    end

    // read back
    assign prdata = reg_sel ? wsg_pkg::PDATA_W'(gain_reg) : '0;
    assign gain   = gain_reg;

endmodule

FILE: rtl/wsg_mac.sv
// shared multiply-accumulate unit with 16-bit saturation of the result
// depends on wsg_pkg
module wsg_mac
(
    input  logic                             clk,
    input  wsg_pkg::mac_op_t                 op,
    output logic signed [wsg_pkg::PCM_W-1:0] sat_sample
);

    localparam int PROD_W = wsg_pkg::ACC_W + 9;

    logic signed [wsg_pkg::ACC_W-1:0] acc_reg;
    logic signed [wsg_pkg::ACC_W-1:0] acc_next;
    logic signed [wsg_pkg::ACC_W-1:0] mul_a;
    logic signed [wsg_pkg::ACC_W-1:0] acc_base;
    logic signed [8:0]                mul_b;
    logic signed [PROD_W-1:0]         prod;

    // operand select: sample for mixing, accumulator for gain scaling
    always_comb
    begin
        mul_a = op.scale ? acc_reg
                         : {{(wsg_pkg::ACC_W-wsg_pkg::SAMPLE_W){op.sample[wsg_pkg::SAMPLE_W-1]}},
                            op.sample};
        mul_b    = $signed({1'b0, op.coef});
        prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
        acc_base = op.clear ? '0 : acc_reg;
        acc_next = acc_base + $signed(prod[wsg_pkg::ACC_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (op.en)
        begin
            acc_reg <= acc_next;
        end
    end

    // clamp to signed 16 bits
    always_comb
    begin
        if (acc_reg > $signed(wsg_pkg::ACC_W'(32767)))
        begin
            sat_sample = 16'sh7fff;
        end
        else if (acc_reg < $signed(-wsg_pkg::ACC_W'(32768)))
        begin
            sat_sample = 16'sh8000;
        end
        else
        begin
            sat_sample = acc_reg[wsg_pkg::PCM_W-1:0];
        end
    end

endmodule

FILE: rtl/wavetable_sound_generator.sv
// top level of the three-voice wavetable sound generator
// depends on wsg_pkg, wsg_apb, wsg_mac and wavetable_sound_generator_assert.svh
`include "wavetable_sound_generator_assert.svh"

// Register writes, wave and explosion memory writes and explosion triggers complete
// on acceptance (req_ready stays high). On a sample tick one multiplier is shared, so
// the three voices, the explosion byte and the gain scaling go through it one after
// another before sample_valid, each voice in the cycle after its wave memory read.
// req_ready is low for the whole tick and stays low while the previous sample still
// waits to be taken. There is no clearing pass after reset; wave and explosion
// memory contents are valid only once written.
module wavetable_sound_generator
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [wsg_pkg::PADDR_W-1:0]          paddr,
    input  logic [wsg_pkg::PDATA_W-1:0]          pwdata,
    output logic [wsg_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready,
    // request channel
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  logic [2:0]                           action,
    input  logic [4:0]                           reg_address,
    input  logic [7:0]                           wave_address,
    input  logic [11:0]                          boom_address,
    input  logic [7:0]                           data_value,
    input  logic [12:0]                          boom_length,
    input  logic                                 game_active,
    // sample channel
    output logic                                 sample_valid,
    input  logic                                 sample_ready,
    output logic signed [wsg_pkg::PCM_W-1:0]     pcm_sample
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_SCALE = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    localparam int NV = wsg_pkg::VOICES;
    localparam int PW = wsg_pkg::PHASE_W;

    // step of one voice from the sound registers, kept modulo 2^18
    function automatic logic [PW-1:0] voice_step_f(input logic [31:0][7:0] r, input int v);
        logic [PW-1:0] s;
        int            b;
        b = v * wsg_pkg::VOICE_STRIDE;
        s = (v == 0) ? PW'(r[5'(wsg_pkg::STEP_LOW_REG)]) : '0;
        s = s + (PW'(r[5'(b + wsg_pkg::STEP_REG_BASE)])     << 4)
              + (PW'(r[5'(b + wsg_pkg::STEP_REG_BASE + 1)]) << 8)
              + (PW'(r[5'(b + wsg_pkg::STEP_REG_BASE + 2)]) << 12)
              + (PW'(r[5'(b + wsg_pkg::STEP_REG_BASE + 3)]) << 16);
        return s;
    endfunction

    state_t                      state_reg, state_next;
    logic [2:0]                  cnt_reg, cnt_next;
    logic [31:0][7:0]            snd_reg;
    logic [PW-1:0]               phase_reg [NV];
    logic [PW-1:0]               phase_next [NV];
    logic [PW-1:0]               step_reg [NV];
    logic [PW-1:0]               step_next [NV];
    logic [7:0]                  vol_reg [NV];
    logic [7:0]                  vol_next [NV];
    logic [2:0]                  sel_reg [NV];
    logic [2:0]                  sel_next [NV];
    logic [13:0]                 boom_rem_reg, boom_rem_next;
    logic [wsg_pkg::BOOM_AW-1:0] boom_ptr_reg, boom_ptr_next;
    logic [wsg_pkg::BLOCK_W-1:0] block_pos_reg, block_pos_next;
    logic                        sample_valid_reg, sample_valid_next;
    logic signed [wsg_pkg::PCM_W-1:0] pcm_sample_reg;

    logic [7:0]                  wave_mem [256];
    logic [7:0]                  boom_mem [wsg_pkg::BOOM_DEPTH];
    logic [7:0]                  wave_raddr;
    logic [7:0]                  wave_rdata_reg;
    logic [7:0]                  boom_rdata_reg;

    logic                        req_accept;
    logic                        out_load;
    logic                        boom_in_range;
    wsg_pkg::action_t            act;
    wsg_pkg::mac_op_t            mac_op;
    logic signed [wsg_pkg::PCM_W-1:0] sat_sample;
    logic [wsg_pkg::GAIN_W-1:0]  gain;

    // configuration register
    wsg_apb u_apb
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gain    (gain)
    );

    // shared multiplier and accumulator
    wsg_mac u_mac
    (
        .clk        (clk),
        .op         (mac_op),
        .sat_sample (sat_sample)
    );

    assign act           = wsg_pkg::action_t'(action);
    assign req_ready     = (state_reg == S_IDLE);
    assign req_accept    = req_valid && req_ready;
    assign boom_in_range = ({1'b0, boom_address} < 13'(wsg_pkg::BOOM_DEPTH));
    assign out_load      = (state_reg == S_OUT) && (!sample_valid_reg || sample_ready);

    // sound register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snd_reg <= '0;
        end
        else if (req_accept && act == wsg_pkg::ACT_REG_WR)
        begin
            snd_reg[reg_address] <= data_value;
        end
    end

    // wave memory read address for the voice in turn
    always_comb
    begin
        wave_raddr = '0;
        unique case (cnt_reg)
            3'd0:    wave_raddr = {sel_reg[0], phase_reg[0][PW-1 -: 5]};
            3'd1:    wave_raddr = {sel_reg[1], phase_reg[1][PW-1 -: 5]};
            3'd2:    wave_raddr = {sel_reg[2], phase_reg[2][PW-1 -: 5]};
            default: wave_raddr = '0;
        endcase
    end

    // wave and explosion memories
    always_ff @(posedge clk)
    begin
        if (req_accept && act == wsg_pkg::ACT_WAVE_WR)
        begin
            wave_mem[wave_address] <= data_value;
        end
        wave_rdata_reg <= wave_mem[wave_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (req_accept && act == wsg_pkg::ACT_BOOM_WR && boom_in_range)
        begin
            boom_mem[boom_address[wsg_pkg::BOOM_AW-1:0]] <= data_value;
        end
        boom_rdata_reg <= boom_mem[boom_ptr_reg];
    end

    // operation handed to the shared unit
    // a silent voice or an idle explosion contributes a zero sample
    always_comb
    begin
        mac_op = '0;
        if (state_reg == S_RUN)
        begin
            unique case (cnt_reg)
                3'd1:
                begin
                    mac_op.en     = 1'b1;
                    mac_op.clear  = 1'b1;
                    mac_op.coef   = vol_reg[0];
                    if (vol_reg[0] != '0)
                    begin
                        mac_op.sample = $signed(wave_rdata_reg);
                    end
                end
                3'd2:
                begin
                    mac_op.en     = 1'b1;
                    mac_op.coef   = vol_reg[1];
                    if (vol_reg[1] != '0)
                    begin
                        mac_op.sample = $signed(wave_rdata_reg);
                    end
                end
                3'd3:
                begin
                    mac_op.en     = 1'b1;
                    mac_op.coef   = vol_reg[2];
                    if (vol_reg[2] != '0)
                    begin
                        mac_op.sample = $signed(wave_rdata_reg);
                    end
                end
                3'd4:
                begin
                    mac_op.en     = 1'b1;
                    mac_op.coef   = {7'd0, (boom_rem_reg != '0)};
                    if (boom_rem_reg != '0)
                    begin
                        mac_op.sample = $signed(boom_rdata_reg);
                    end
                end
                default:
                begin
                    mac_op = '0;
                end
            endcase
        end
        else if (state_reg == S_SCALE)
        begin
            mac_op.en    = 1'b1;
            mac_op.clear = 1'b1;
            mac_op.scale = 1'b1;
            mac_op.coef  = {1'b0, gain};
        end
    end

    // sequencer and voice state
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        boom_rem_next     = boom_rem_reg;
        boom_ptr_next     = boom_ptr_reg;
        block_pos_next    = block_pos_reg;
        sample_valid_next = sample_valid_reg && !sample_ready;
        for (int v = 0; v < NV; v++)
        begin
            phase_next[v] = phase_reg[v];
            step_next[v]  = step_reg[v];
            vol_next[v]   = vol_reg[v];
            sel_next[v]   = sel_reg[v];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    unique case (act)
                        wsg_pkg::ACT_BOOM_GO:
                        begin
                            if (game_active)
                            begin
                                boom_rem_next = {boom_length, 1'b0};
                                boom_ptr_next = '0;
                            end
                        end
                        wsg_pkg::ACT_TICK:
                        begin
                            // voices latch their settings at the start of a block
                            if (block_pos_reg == '0)
                            begin
                                for (int v = 0; v < NV; v++)
                                begin
                                    vol_next[v] = snd_reg[5'(wsg_pkg::VOL_REG_BASE
                                                  + v * wsg_pkg::VOICE_STRIDE)];
                                    if (vol_next[v] != '0)
                                    begin
                                        step_next[v] = voice_step_f(snd_reg, v);
                                        sel_next[v]  = snd_reg[5'(wsg_pkg::SEL_REG_BASE
                                                       + v * wsg_pkg::VOICE_STRIDE)][2:0];
                                    end
                                end
                            end
                            if (block_pos_reg == wsg_pkg::BLOCK_W'(wsg_pkg::BLOCK_SAMPLES - 1))
                            begin
                                block_pos_next = '0;
                            end
                            else
                            begin
                                block_pos_next = block_pos_reg + 1'b1;
                            end
                            cnt_next   = '0;
                            state_next = S_RUN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RUN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 3'd4)
                begin
                    // explosion playback advances every second tick
                    if (boom_rem_reg != '0)
                    begin
                        if (boom_rem_reg[0])
                        begin
                            if (boom_ptr_reg == wsg_pkg::BOOM_AW'(wsg_pkg::BOOM_DEPTH - 1))
                            begin
                                boom_ptr_next = '0;
                            end
                            else
                            begin
                                boom_ptr_next = boom_ptr_reg + 1'b1;
                            end
                        end
                        boom_rem_next = boom_rem_reg - 1'b1;
                    end
                    for (int v = 0; v < NV; v++)
                    begin
                        phase_next[v] = phase_reg[v] + step_reg[v];
                    end
                    cnt_next   = '0;
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    sample_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            boom_rem_reg     <= '0;
            boom_ptr_reg     <= '0;
            block_pos_reg    <= '0;
            sample_valid_reg <= 1'b0;
            for (int v = 0; v < NV; v++)
            begin
                phase_reg[v] <= '0;
                step_reg[v]  <= '0;
                vol_reg[v]   <= '0;
                sel_reg[v]   <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            boom_rem_reg     <= boom_rem_next;
            boom_ptr_reg     <= boom_ptr_next;
            block_pos_reg    <= block_pos_next;
            sample_valid_reg <= sample_valid_next;
            for (int v = 0; v < NV; v++)
            begin
                phase_reg[v] <= phase_next[v];
                step_reg[v]  <= step_next[v];
                vol_reg[v]   <= vol_next[v];
                sel_reg[v]   <= sel_next[v];
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pcm_sample_reg <= sat_sample;
        end
    end

    assign sample_valid = sample_valid_reg;
    assign pcm_sample   = pcm_sample_reg;

    // checks
    `WSG_ASSERT_NEXT(a_tick_starts_run, req_accept && act == wsg_pkg::ACT_TICK,
        state_reg == S_RUN && cnt_reg == 3'd0, "tick beat did not start the mixing sequence")
    `WSG_ASSERT_NOW(a_valid_from_out, $rose(sample_valid_reg),
        $past(state_reg) == S_OUT, "sample beat raised outside the output step")
    `WSG_ASSERT_NOW(a_run_count, state_reg == S_RUN,
        cnt_reg <= 3'd4, "mixing step count out of range")
    `WSG_ASSERT_NOW(a_boom_ptr_range, boom_rem_reg != '0,
        {1'b0, boom_ptr_reg} < (wsg_pkg::BOOM_AW + 1)'(wsg_pkg::BOOM_DEPTH),
        "explosion pointer beyond memory depth")

endmodule

FILE: tb/wsg_sample_checker.sv
`timescale 1ns / 1ps
// pcm sample scoreboard for the wavetable sound generator: follows request, sample
// and configuration beats, keeps its own copy of the voice and explosion state
// uses types and constants from wsg_pkg
module wsg_sample_checker
    import wsg_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [PADDR_W-1:0]         paddr,
    input  logic [PDATA_W-1:0]         pwdata,
    input  logic                       pready,
    input  logic                       req_valid,
    input  logic                       req_ready,
    input  logic [2:0]                 action,
    input  logic [4:0]                 reg_address,
    input  logic [7:0]                 wave_address,
    input  logic [11:0]                boom_address,
    input  logic [7:0]                 data_value,
    input  logic [12:0]                boom_length,
    input  logic                       game_active,
    input  logic                       sample_valid,
    input  logic                       sample_ready,
    input  logic signed [PCM_W-1:0]    pcm_sample,
    output int                         fail_count,
    output int                         samples_due
);

    localparam logic [PADDR_W-1:0] GAIN_ADDR = PADDR_W'(4 * REG_GAIN);
    localparam int PCM_MAX = 2 ** (PCM_W - 1) - 1;
    localparam int PCM_MIN = -(2 ** (PCM_W - 1));

    // mirrored block state
    logic [7:0]               sound_regs [32];
    logic [7:0]               wave_mem [256];
    logic [7:0]               boom_mem [BOOM_DEPTH];
    logic [PHASE_W-1:0]       voice_phase [VOICES];
    logic [PHASE_W-1:0]       voice_step [VOICES];
    logic [7:0]               voice_vol [VOICES];
    logic [2:0]               voice_sel [VOICES];
    logic [13:0]              boom_left;
    logic [BOOM_AW-1:0]       boom_ptr;
    logic [BLOCK_W-1:0]       block_pos;
    logic [GAIN_W-1:0]        gain;
    logic signed [PCM_W-1:0]  expected_pcm [$];

    // block start: voices with a nonzero volume pick up step and wave select
    function automatic void latch_voices();
        int base;
        int step_sum;
        for (int v = 0; v < VOICES; v++) begin
            base = v * VOICE_STRIDE;
            voice_vol[v] = sound_regs[VOL_REG_BASE + base];
            if (voice_vol[v] != 0) begin
                step_sum = (v == 0) ? int'(sound_regs[STEP_LOW_REG]) : 0;
                for (int k = 0; k < 4; k++)
                    step_sum += int'(sound_regs[STEP_REG_BASE + base + k]) << (4 * (k + 1));
                voice_step[v] = step_sum[PHASE_W-1:0];
                voice_sel[v]  = sound_regs[SEL_REG_BASE + base][2:0];
            end
        end
    endfunction

    // one sample tick: mix voices and explosion, scale, clamp, advance phases
    function automatic logic signed [PCM_W-1:0] next_pcm();
        int mix;
        int scaled;
        logic [7:0] smp;
        if (block_pos == 0)
            latch_voices();
        mix = 0;
        for (int v = 0; v < VOICES; v++) begin
            if (voice_vol[v] != 0) begin
                smp = wave_mem[{voice_sel[v], voice_phase[v][PHASE_W-1 -: 5]}];
                mix += int'(voice_vol[v]) * int'($signed(smp));
            end
        end
        // explosion byte is heard twice before the pointer moves on
        if (boom_left != 0) begin
            mix += int'($signed(boom_mem[boom_ptr]));
            if (boom_left[0])
                boom_ptr = (int'(boom_ptr) == BOOM_DEPTH - 1) ? '0 : boom_ptr + 1'b1;
            boom_left = boom_left - 1'b1;
        end
        scaled = mix * int'(gain);
        if (scaled > PCM_MAX)
            scaled = PCM_MAX;
        else if (scaled < PCM_MIN)
            scaled = PCM_MIN;
        for (int v = 0; v < VOICES; v++)
            voice_phase[v] = voice_phase[v] + voice_step[v];
        block_pos = (int'(block_pos) == BLOCK_SAMPLES - 1) ? '0 : block_pos + 1'b1;
        return scaled[PCM_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic signed [PCM_W-1:0] want;
        if (!rst_n)
        begin
            foreach (sound_regs[i]) sound_regs[i] = '0;
            foreach (wave_mem[i]) wave_mem[i] = '0;
            foreach (boom_mem[i]) boom_mem[i] = '0;
            for (int v = 0; v < VOICES; v++)
            begin
                voice_phase[v] = '0;
                voice_step[v]  = '0;
                voice_vol[v]   = '0;
                voice_sel[v]   = '0;
            end
            boom_left   = '0;
            boom_ptr    = '0;
            block_pos   = '0;
            gain        = GAIN_RESET;
            expected_pcm.delete();
            fail_count  = 0;
            samples_due = 0;
        end
        else
        begin
            // gain register write
            if (psel && penable && pwrite && pready && paddr == GAIN_ADDR)
                gain = pwdata[GAIN_W-1:0];

            // request beat
            if (req_valid && req_ready)
            begin
                case (action)
                    ACT_REG_WR:  sound_regs[reg_address] = data_value;
                    ACT_WAVE_WR: wave_mem[wave_address] = data_value;
                    ACT_BOOM_WR:
                        if (int'(boom_address) < BOOM_DEPTH)
                            boom_mem[boom_address] = data_value;
                    ACT_BOOM_GO:
                        if (game_active)
                        begin
                            boom_left = {boom_length, 1'b0};
                            boom_ptr  = '0;
                        end
                    ACT_TICK:    expected_pcm.push_back(next_pcm());
                    default:     ;
                endcase
            end

            // sample beat
            if (sample_valid && sample_ready)
            begin
                if (expected_pcm.size() == 0)
                begin
                    $error("pcm_sample beat with no sample expected, got %0d", pcm_sample);
                    fail_count++;
                end
                else
                begin
                    want = expected_pcm.pop_front();
                    if (pcm_sample !== want)
                    begin
                        $error("pcm_sample mismatch: expected %0d, got %0d", want, pcm_sample);
                        fail_count++;
                    end
                end
            end
            samples_due = expected_pcm.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// top of the wavetable sound generator testbench: clock, reset, request and
// configuration stimulus, sample back-pressure and verdict; uses wsg_pkg and wsg_sample_checker
module tb_top;
    import wsg_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 20;
    localparam int BOOM_FILL     = 32;
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam logic [PADDR_W-1:0] GAIN_ADDR = PADDR_W'(4 * REG_GAIN);

    logic                      clk;
    logic                      rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [PADDR_W-1:0]        paddr;
    logic [PDATA_W-1:0]        pwdata;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      req_valid;
    logic                      req_ready;
    logic [2:0]                action;
    logic [4:0]                reg_address;
    logic [7:0]                wave_address;
    logic [11:0]               boom_address;
    logic [7:0]                data_value;
    logic [12:0]               boom_length;
    logic                      game_active;
    logic                      sample_valid;
    logic                      sample_ready;
    logic signed [PCM_W-1:0]   pcm_sample;

    int fail_count;
    int samples_due;
    int tx_idle_pct;
    int rx_stall_pct;
    bit hold_request;

    wavetable_sound_generator u_dut (.*);

    wsg_sample_checker u_checker (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(HALF_PERIOD) clk = ~clk;
    end

    // sample side back-pressure, with one long hold-off on request
    initial
    begin : rx_side
        int hold_left;
        hold_left    = 0;
        sample_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                sample_ready <= 1'b0;
                hold_left--;
            end
            else
                sample_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog on cycles without any beat
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (sample_valid && sample_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // one request beat, with random sender gaps in front
    task automatic offer(input logic [2:0] act, input logic [4:0] ra, input logic [7:0] wa,
                         input logic [11:0] ba, input logic [7:0] dv, input logic [12:0] bl,
                         input logic ga);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid    <= 1'b1;
        action       <= act;
        reg_address  <= ra;
        wave_address <= wa;
        boom_address <= ba;
        data_value   <= dv;
        boom_length  <= bl;
        game_active  <= ga;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic put_reg(input int idx, input logic [7:0] val);
        offer(ACT_REG_WR, idx[4:0], 8'($urandom), 12'($urandom), val, 13'($urandom),
              1'($urandom));
    endtask

    task automatic put_wave(input int addr, input logic [7:0] val);
        offer(ACT_WAVE_WR, 5'($urandom), addr[7:0], 12'($urandom), val, 13'($urandom),
              1'($urandom));
    endtask

    task automatic put_boom(input int addr, input logic [7:0] val);
        offer(ACT_BOOM_WR, 5'($urandom), 8'($urandom), addr[11:0], val, 13'($urandom),
              1'($urandom));
    endtask

    task automatic arm_boom(input int len, input bit active);
        offer(ACT_BOOM_GO, 5'($urandom), 8'($urandom), 12'($urandom), 8'($urandom),
              len[12:0], active);
    endtask

    task automatic tick_run(input int count);
        repeat (count)
            offer(ACT_TICK, 5'($urandom), 8'($urandom), 12'($urandom), 8'($urandom),
                  13'($urandom), 1'($urandom));
    endtask

    task automatic poke_spare();
        offer(3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO)), 5'($urandom), 8'($urandom),
              12'($urandom), 8'($urandom), 13'($urandom), 1'($urandom));
    endtask

    // drop valid, wait for every sample, then let trailing writes finish
    task automatic settle();
        req_valid <= 1'b0;
        while (samples_due != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_gain(input logic [GAIN_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= GAIN_ADDR;
        pwdata  <= PDATA_W'(val);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stimulus
    initial
    begin : stimulus
        int items;
        int pick;
        int count;
        int base;
        int v;
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_valid    = 1'b0;
        action       = '0;
        reg_address  = '0;
        wave_address = '0;
        boom_address = '0;
        data_value   = '0;
        boom_length  = '0;
        game_active  = 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill the wave memory and the head of the explosion memory; explosions
        // stay short enough that playback only reads written bytes
        for (int a = 0; a < 256; a++)
            put_wave(a, 8'($urandom));
        for (int a = 0; a < BOOM_FILL; a++)
            put_boom(a, 8'($urandom));

        // silent output at the reset gain
        tick_run(2);

        // extreme samples and a full-scale voice 0 on wave 7
        put_wave(0, 8'h7F);
        put_wave(255, 8'h80);
        put_boom(0, 8'h80);
        put_boom(BOOM_DEPTH - 1, 8'h7F);
        put_reg(SEL_REG_BASE, 8'hFF);
        put_reg(STEP_LOW_REG, 8'hFF);
        for (int k = 0; k < 4; k++)
            put_reg(STEP_REG_BASE + k, 8'hFF);
        put_reg(VOL_REG_BASE, 8'hFF);
        put_reg(VOL_REG_BASE + 2 * VOICE_STRIDE, 8'h01);
        tick_run(3);

        // explosion: ignored when inactive, restart while playing, zero length disarms
        arm_boom(BOOM_DEPTH, 1'b0);
        tick_run(1);
        arm_boom(BOOM_DEPTH, 1'b1);
        tick_run(3);
        arm_boom(2, 1'b1);
        tick_run(5);
        arm_boom(7, 1'b1);
        tick_run(1);
        arm_boom(0, 1'b1);
        tick_run(2);

        // unused action codes and edge register addresses
        poke_spare();
        poke_spare();
        put_reg(31, 8'h00);
        put_reg(0, 8'hFF);

        // random phases under different gain and flow settings
        for (int p = 0; p < 4; p++)
        begin
            settle();
            case (p)
                0: begin write_gain(7'd64); tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin write_gain(7'd0);  tx_idle_pct = 61; rx_stall_pct = 0;  end
                2: begin write_gain(7'd1);  tx_idle_pct = 0;  rx_stall_pct = 61; end
                default: begin write_gain(7'd63); tx_idle_pct = 15; rx_stall_pct = 15; end
            endcase
            items = 0;
            if (p == 0)
            begin
                // long receiver hold-off while ticks keep coming
                hold_request = 1'b1;
                tick_run(4);
                items = 4;
            end
            while (items < PHASE_ITEMS)
            begin
                pick = $urandom_range(99);
                if (pick < 45)
                begin
                    count = $urandom_range(8, 1);
                    tick_run(count);
                    items += count;
                end
                else if (pick < 58)
                begin
                    // whole voice set-up, volume last
                    v    = $urandom_range(VOICES - 1);
                    base = v * VOICE_STRIDE;
                    if (v == 0)
                        put_reg(STEP_LOW_REG, 8'($urandom));
                    for (int k = 0; k < 4; k++)
                        put_reg(STEP_REG_BASE + base + k, 8'($urandom));
                    put_reg(SEL_REG_BASE + base, 8'($urandom));
                    put_reg(VOL_REG_BASE + base,
                            ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom));
                    items += 6;
                end
                else if (pick < 68)
                begin
                    put_reg($urandom_range(31), 8'($urandom));
                    items++;
                end
                else if (pick < 76)
                begin
                    put_wave($urandom_range(255), 8'($urandom));
                    items++;
                end
                else if (pick < 84)
                begin
                    put_boom($urandom_range(BOOM_DEPTH - 1), 8'($urandom));
                    items++;
                end
                else if (pick < 94)
                begin
                    arm_boom($urandom_range(BOOM_FILL), $urandom_range(9) != 0);
                    items++;
                end
                else
                begin
                    poke_spare();
                    items++;
                end
            end
        end

        settle();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: wavetable_sound_generator.f
+incdir+rtl
rtl/wsg_pkg.sv
rtl/wsg_apb.sv
rtl/wsg_mac.sv
rtl/wavetable_sound_generator.sv
tb/wsg_sample_checker.sv
tb/tb_top.sv
